### sv/brp_pkg.sv
// Shared types, codes and a helper function for the byte range prosody reducer.
`timescale 1ns / 1ps

package brp_pkg;

    // Request opcodes.
    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_TEXT     = 3'd1;
    localparam logic [2:0] OP_WORD     = 3'd2;
    localparam logic [2:0] OP_SYLLABLE = 3'd3;
    localparam logic [2:0] OP_PHONEME  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_WORD     = 2'd0;
    localparam logic [1:0] KIND_SYLLABLE = 2'd1;
    localparam logic [1:0] KIND_PHONEME  = 2'd2;

    // One request item.
    typedef struct packed {
        logic [2:0]         opcode;
        logic [15:0]        byte_offset;
        logic [15:0]        byte_length;
        logic [7:0]         emphasis_in;
        logic signed [15:0] pitch_in;
        logic signed [15:0] rate_in;
        logic [15:0]        syllable_id;
    } t_req;

    // One result item.
    typedef struct packed {
        logic [1:0]         item_kind;
        logic [7:0]         emphasis_out;
        logic signed [15:0] pitch_out;
        logic signed [15:0] rate_out;
        logic               assigned;
    } t_rsp;

    // One entry of the byte map or the syllable table.
    typedef struct packed {
        logic [7:0]  emph;
        logic [15:0] pitch;
        logic [15:0] rate;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sweep;
        logic walk;
        logic syl_read;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic walk_done;
        logic out_free;
    } t_status;

    // Magnitude of a 16-bit two's complement value; the most negative value gives 32768.
    function automatic logic [16:0] mag16(input logic [15:0] v);
        logic [16:0] m;
        if (v[15]) begin
            m = 17'h10000 - {1'b0, v};
        end else begin
            m = {1'b0, v};
        end
        return m;
    endfunction

endpackage

### sv/brp_ctrl.sv
// Controller state machine that sequences sweeps, range walks and result hand-off.
`timescale 1ns / 1ps

module brp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [2:0]        i_opcode,
    input  brp_pkg::t_status  i_status,
    output brp_pkg::t_cmd     o_cmd,
    output logic              o_req_stall
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_WALK,
        S_PHON,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT, S_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_opcode)
                        brp_pkg::OP_CLEAR:    n_state = S_CLEAR;
                        brp_pkg::OP_WORD:     n_state = S_WALK;
                        brp_pkg::OP_SYLLABLE: n_state = S_WALK;
                        brp_pkg::OP_PHONEME:  n_state = S_PHON;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = S_OUT;
                end
            end
            S_PHON: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode from the current state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_req_valid;
        o_cmd.sweep    = (r_state == S_INIT) || (r_state == S_CLEAR);
        o_cmd.walk     = (r_state == S_WALK);
        o_cmd.syl_read = (r_state == S_PHON);
        o_cmd.emit     = (r_state == S_OUT) && i_status.out_free;
    end

    assign o_req_stall = (r_state != S_IDLE);

endmodule

### sv/brp_dp.sv
// Datapath: byte map memory, syllable table, range accumulators and result register.
`timescale 1ns / 1ps

module brp_dp #(
    parameter int unsigned MAP_DEPTH      = 4096,
    parameter int unsigned SYLLABLE_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brp_pkg::t_req     i_req,
    input  brp_pkg::t_cmd     i_cmd,
    output brp_pkg::t_status  o_status,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output brp_pkg::t_rsp     o_rsp
);

    localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned SW = (SYLLABLE_DEPTH > 1) ? $clog2(SYLLABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(SYLLABLE_DEPTH + 1);
    localparam logic [16:0] MAP_END   = 17'(MAP_DEPTH);
    localparam logic [16:0] MAP_LAST  = 17'(MAP_DEPTH - 1);
    localparam logic [CW-1:0] SYL_END = CW'(SYLLABLE_DEPTH);

    brp_pkg::t_entry r_map [MAP_DEPTH];
    brp_pkg::t_entry r_syl [SYLLABLE_DEPTH];

    brp_pkg::t_req   r_req;
    brp_pkg::t_entry r_map_rd;
    brp_pkg::t_entry r_syl_rd;
    brp_pkg::t_entry r_acc;
    brp_pkg::t_rsp   r_rsp;
    logic [16:0]     r_cur;
    logic [15:0]     r_left;
    logic            r_rd_pend;
    logic            r_syl_hit;
    logic [CW-1:0]   r_count;
    logic            r_rsp_valid;

    logic            avail;
    logic            step;
    logic            map_we;
    logic [AW-1:0]   map_wr_idx;
    brp_pkg::t_entry map_wr_data;
    brp_pkg::t_entry text_entry;
    logic            syl_we;
    logic            out_free;

    // Range walk: one map entry is read per cycle while bytes remain inside the map.
    assign avail = (r_left != 16'd0) && (r_cur < MAP_END);
    assign step  = i_cmd.walk && avail;

    // Map write port: the clearing sweep or a text byte write.
    assign text_entry = '{emph: i_req.emphasis_in, pitch: i_req.pitch_in, rate: i_req.rate_in};

    always_comb begin
        if (i_cmd.sweep) begin
            map_we      = 1'b1;
            map_wr_idx  = r_cur[AW-1:0];
            map_wr_data = '0;
        end else begin
            map_we      = i_cmd.load && (i_req.opcode == brp_pkg::OP_TEXT)
                          && ({1'b0, i_req.byte_offset} < MAP_END);
            map_wr_idx  = i_req.byte_offset[AW-1:0];
            map_wr_data = text_entry;
        end
    end

    assign out_free = !r_rsp_valid || !i_rsp_stall;
    assign syl_we   = i_cmd.emit && (r_req.opcode == brp_pkg::OP_SYLLABLE) && (r_count < SYL_END);

    // Byte map memory.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_wr_idx] <= map_wr_data;
        end
        r_map_rd <= r_map[r_cur[AW-1:0]];
    end

    // Syllable table memory.
    always_ff @(posedge i_clk) begin
        if (syl_we) begin
            r_syl[r_count[SW-1:0]] <= r_acc;
        end
        if (i_cmd.syl_read) begin
            r_syl_rd <= r_syl[r_req.syllable_id[SW-1:0]];
        end
    end

    // Request latch, accumulators and lookup result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_left <= i_req.byte_length;
            r_acc  <= '0;
        end else begin
            if (step) begin
                r_left <= r_left - 16'd1;
            end
            if (r_rd_pend) begin
                if (r_map_rd.emph > r_acc.emph) begin
                    r_acc.emph <= r_map_rd.emph;
                end
                if (brp_pkg::mag16(r_map_rd.pitch) > brp_pkg::mag16(r_acc.pitch)) begin
                    r_acc.pitch <= r_map_rd.pitch;
                end
                if (brp_pkg::mag16(r_map_rd.rate) > brp_pkg::mag16(r_acc.rate)) begin
                    r_acc.rate <= r_map_rd.rate;
                end
            end
        end
        if (i_cmd.syl_read) begin
            r_syl_hit <= ({1'b0, r_req.syllable_id} < 17'(r_count));
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (r_req.opcode)
                brp_pkg::OP_WORD: begin
                    r_rsp <= '{item_kind: brp_pkg::KIND_WORD, emphasis_out: r_acc.emph,
                               pitch_out: r_acc.pitch, rate_out: r_acc.rate, assigned: 1'b1};
                end
                brp_pkg::OP_SYLLABLE: begin
                    r_rsp <= '{item_kind: brp_pkg::KIND_SYLLABLE, emphasis_out: r_acc.emph,
                               pitch_out: r_acc.pitch, rate_out: r_acc.rate, assigned: 1'b1};
                end
                default: begin
                    if (r_syl_hit) begin
                        r_rsp <= '{item_kind: brp_pkg::KIND_PHONEME,
                                   emphasis_out: r_syl_rd.emph, pitch_out: r_syl_rd.pitch,
                                   rate_out: r_syl_rd.rate, assigned: 1'b1};
                    end else begin
                        r_rsp <= '{item_kind: brp_pkg::KIND_PHONEME, emphasis_out: 8'd0,
                                   pitch_out: 16'sd0, rate_out: 16'sd0, assigned: 1'b0};
                    end
                end
            endcase
        end
    end

    // Control registers: cursor, read pipeline flag, syllable count, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_rd_pend   <= 1'b0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_req.opcode == brp_pkg::OP_CLEAR) begin
                    r_cur <= '0;
                end else begin
                    r_cur <= {1'b0, i_req.byte_offset};
                end
            end else if (i_cmd.sweep || step) begin
                r_cur <= r_cur + 17'd1;
            end
            r_rd_pend <= step;

            if (i_cmd.sweep && (r_cur == MAP_LAST)) begin
                r_count <= '0;
            end else if (syl_we) begin
                r_count <= r_count + CW'(1);
            end

            if (i_cmd.emit) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_status.sweep_last = (r_cur == MAP_LAST);
    assign o_status.walk_done  = !avail && !r_rd_pend;
    assign o_status.out_free   = out_free;

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### sv/byte_range_prosody_reduce.sv
// Top level of the byte range prosody reducer: controller plus datapath.
//
//   Channel   | Direction | Handshake                  | Payload
//   ----------+-----------+----------------------------+---------------------
//   request   | in        | i_req_valid / o_req_stall  | i_req (brp_pkg::t_req)
//   result    | out       | o_rsp_valid / i_rsp_stall  | o_rsp (brp_pkg::t_rsp)
//
// One request is handled at a time. A text write is done as it is taken, a phoneme lookup
// reads the syllable table and then emits its result, and a word or syllable range walks
// the bytes that fall inside the map; the walk reads one map entry per cycle from the
// single map read port, and the last read is registered before the walk ends.
// A clear request sweeps the whole map, one entry a cycle.
// After reset the same sweep runs before the first request is taken.
// A result waits in the output register while the next request is already accepted;
// a stalled result holds back only the next request that has a result of its own.
`timescale 1ns / 1ps

module byte_range_prosody_reduce #(
    parameter int unsigned MAP_DEPTH      = 4096,
    parameter int unsigned SYLLABLE_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  brp_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output brp_pkg::t_rsp  o_rsp
);

    brp_pkg::t_cmd    cmd;
    brp_pkg::t_status status;

    // Sequencing.
    brp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_opcode    (i_req.opcode),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    // Storage and arithmetic.
    brp_dp #(
        .MAP_DEPTH      (MAP_DEPTH),
        .SYLLABLE_DEPTH (SYLLABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule
